@@ hdl/acl_pkg.sv @@
// Package: types, constants and arithmetic helpers of the adaptive conductance neuron array
`default_nettype none
package acl_pkg;

  localparam int NEURON_COUNT = 1024;
  localparam int ADDR_W       = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int FQ_DEPTH     = 4;
  localparam int FQ_PTR_W     = 2;
  localparam int OQ_DEPTH     = 16;
  localparam int OQ_PTR_W     = 4;
  localparam int PIPE_LAST    = 9;

  localparam logic signed [31:0] E_REST        = -32'sd1174405;
  localparam logic signed [31:0] E_REV         = -32'sd1342177;
  localparam logic signed [31:0] V_THRESH_BASE = -32'sd838861;
  localparam logic signed [31:0] DTHR          = 32'sd1677722;

  typedef enum logic [2:0] {
    REG_AMPA_DECAY   = 3'd0,
    REG_GABA_DECAY   = 3'd1,
    REG_ADAPT_DECAY  = 3'd2,
    REG_THRESH_DECAY = 3'd3,
    REG_NMDA_RATE    = 3'd4,
    REG_MEM_RATE     = 3'd5,
    REG_AMPA_FRAC    = 3'd6,
    REG_ADAPT_INC    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [9:0]  neuron_index;
    logic [30:0] excit_increment;
    logic [30:0] inhib_increment;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         spike_index;
    logic               fired;
    logic signed [31:0] membrane_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ampa_decay;
    logic [15:0] gaba_decay;
    logic [15:0] adapt_decay;
    logic [15:0] thresh_decay;
    logic [15:0] nmda_rate;
    logic [15:0] mem_rate;
    logic [15:0] ampa_fraction;
    logic [30:0] adapt_increment;
  } cfg_t;

  // item as held in the queue between front and back
  typedef struct packed {
    in_item_t item;
    logic     in_range;
  } work_t;

  typedef struct packed {
    logic signed [31:0] mem;
    logic signed [31:0] th;
    logic signed [31:0] fast;
    logic signed [31:0] slow;
    logic signed [31:0] inhib;
    logic signed [31:0] adapt;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // round to nearest, ties towards +infinity
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

endpackage
`default_nettype wire

@@ hdl/acl_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module acl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/acl_front.sv @@
// Front part: accepts items, classifies the neuron index and queues them for the back part
`default_nettype none
module acl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire acl_pkg::in_item_t in_item,
  output logic                   q_valid,
  output acl_pkg::work_t         q_head,
  input  wire logic              q_pop
);
  import acl_pkg::*;

  work_t                 q_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [FQ_PTR_W:0]     cnt_r, cnt_nxt;
  logic                  push;
  logic                  pop;
  work_t                 w;

  assign in_stall = (cnt_r == (FQ_PTR_W+1)'(FQ_DEPTH));
  assign push     = in_valid & ~in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop & q_valid;
  assign q_head   = q_r[rd_r];

  // classify: indices past the array bypass the state
  always_comb begin
    w.item     = in_item;
    w.in_range = ({1'b0, in_item.neuron_index} < 11'(NEURON_COUNT));
  end

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (FQ_PTR_W+1)'(push) - (FQ_PTR_W+1)'(pop);
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= w;
    end
  end
endmodule
`default_nettype wire

@@ hdl/acl_core.sv @@
// Back part: state clearing, pipelined neuron update and result queue
`default_nettype none
module acl_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire acl_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire acl_pkg::work_t     q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output acl_pkg::out_item_t      out_item
);
  import acl_pkg::*;

  localparam int NS = PIPE_LAST + 1;

  // pipeline control, one entry per stage
  logic              vld_r [NS];
  logic              rng_r [NS];
  logic [9:0]        idx_r [NS];

  logic              clr_busy_r;
  logic [ADDR_W:0]   clr_cnt_r;
  logic [OQ_PTR_W:0] rsv_r, rsv_nxt;
  logic              hazard, issue;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  state_t            ram_wdata, rd;

  // stage registers
  logic [30:0]        s0_ei_r, s0_ii_r;
  logic signed [31:0] a_mem_r, a_ga_r, a_gg_r, a_gd_r, a_gn_r, a_th_r;
  logic signed [31:0] b_mem_r, b_ga_r, b_gg_r, b_gd_r, b_gn_r, b_th_r;
  logic signed [31:0] c_mem_r, c_ga_r, c_gg_r, c_gd_r, c_gn_r, c_th_r;
  logic signed [49:0] c_prod_r;
  logic signed [31:0] d_mem_r, d_ga_r, d_gg_r, d_gd_r, d_gn_r, d_th_r, d_gi_r;
  logic signed [31:0] e_mem_r, e_ga_r, e_gg_r, e_gd_r, e_gn_r, e_th_r, e_gi_r;
  logic signed [48:0] e_p1_r;
  logic signed [49:0] e_p2_r;
  logic signed [31:0] f_mem_r, f_ga_r, f_gg_r, f_gd_r, f_gn_r, f_th_r, f_gi_r, f_gexc_r;
  logic signed [31:0] g_mem_r, g_ga_r, g_gg_r, g_gd_r, g_gn_r, g_th_r;
  logic signed [54:0] g_exc_r, g_inh_r;
  logic signed [31:0] h_mem_r, h_ga_r, h_gg_r, h_gd_r, h_gn_r, h_th_r;
  logic signed [39:0] h_sum_r;
  logic signed [31:0] i_mem_r, i_ga_r, i_gg_r, i_gd_r, i_gn_r, i_th_r;
  logic signed [56:0] i_prod_r;

  // combinational stage results
  logic signed [31:0] a_mem, a_ga, a_gg;
  logic signed [48:0] b_pa, b_pg, b_pd, b_pt;
  logic signed [32:0] c_diff;
  logic signed [17:0] e_slow_f;
  logic [16:0]        e_slow_u;
  logic signed [32:0] g_nexc;
  logic signed [21:0] g_mem22;
  logic [21:0]        g_above;
  logic signed [31:0] g_above32;
  logic signed [63:0] h_sum;
  logic signed [63:0] j_m;
  logic               j_fire;
  state_t             j_st;

  // result queue
  out_item_t           oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] owr_r, ord_r;
  logic [OQ_PTR_W:0]   ocnt_r;
  logic                opush, opop;
  out_item_t           res;

  acl_ram #(.WIDTH(STATE_W), .DEPTH(NEURON_COUNT)) u_state (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_head.item.neuron_index[ADDR_W-1:0]),
    .rdata (rd)
  );

  // hold back an item whose neuron is still in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NS; k++) begin
      if (vld_r[k] && rng_r[k] && q_head.in_range &&
          (idx_r[k] == q_head.item.neuron_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign issue = q_valid & ~clr_busy_r & ~hazard & (rsv_r < (OQ_PTR_W+1)'(OQ_DEPTH));
  assign q_pop = issue;

  // reserve a result slot per issued item
  assign rsv_nxt = rsv_r + (OQ_PTR_W+1)'(issue) - (OQ_PTR_W+1)'(opop);

  // clearing pass after reset, then write-back from the last stage
  always_comb begin
    ram_we    = clr_busy_r | (vld_r[PIPE_LAST] & rng_r[PIPE_LAST]);
    ram_waddr = clr_busy_r ? clr_cnt_r[ADDR_W-1:0] : idx_r[PIPE_LAST][ADDR_W-1:0];
    if (clr_busy_r) begin
      ram_wdata       = '0;
      ram_wdata.mem   = E_REST;
    end else begin
      ram_wdata = j_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      rsv_r      <= '0;
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (ADDR_W+1)'(NEURON_COUNT - 1)) clr_busy_r <= 1'b0;
      end
      rsv_r    <= rsv_nxt;
      vld_r[0] <= issue;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // advance control tags
  always_ff @(posedge clk) begin
    idx_r[0] <= q_head.item.neuron_index;
    rng_r[0] <= q_head.in_range;
    s0_ei_r  <= q_head.item.excit_increment;
    s0_ii_r  <= q_head.item.inhib_increment;
    for (int k = 1; k < NS; k++) begin
      idx_r[k] <= idx_r[k-1];
      rng_r[k] <= rng_r[k-1];
    end
  end

  // stage A: clamp membrane, add increments
  always_comb begin
    if (rd.mem > 32'sd0)    a_mem = '0;
    else if (rd.mem < E_REV) a_mem = E_REV;
    else                    a_mem = rd.mem;
    a_ga = sat32(64'(rd.fast) + 64'($signed({1'b0, s0_ei_r})));
    a_gg = sat32(64'(rd.inhib) + 64'($signed({1'b0, s0_ii_r})));
  end

  always_ff @(posedge clk) begin
    a_mem_r <= a_mem;
    a_ga_r  <= a_ga;
    a_gg_r  <= a_gg;
    a_gd_r  <= rd.adapt;
    a_gn_r  <= rd.slow;
    a_th_r  <= rd.th;
  end

  // stage B: decays
  always_comb begin
    b_pa = a_ga_r * $signed({1'b0, cfg.ampa_decay});
    b_pg = a_gg_r * $signed({1'b0, cfg.gaba_decay});
    b_pd = a_gd_r * $signed({1'b0, cfg.adapt_decay});
    b_pt = a_th_r * $signed({1'b0, cfg.thresh_decay});
  end

  always_ff @(posedge clk) begin
    b_mem_r <= a_mem_r;
    b_gn_r  <= a_gn_r;
    b_ga_r  <= sat32(rshr(64'(b_pa), 16));
    b_gg_r  <= sat32(rshr(64'(b_pg), 16));
    b_gd_r  <= sat32(rshr(64'(b_pd), 16));
    b_th_r  <= sat32(rshr(64'(b_pt), 16));
  end

  // stage C: slow excitation step product
  assign c_diff = 33'(b_ga_r) - 33'(b_gn_r);

  always_ff @(posedge clk) begin
    c_prod_r <= c_diff * $signed({1'b0, cfg.nmda_rate});
    c_mem_r  <= b_mem_r;
    c_ga_r   <= b_ga_r;
    c_gg_r   <= b_gg_r;
    c_gd_r   <= b_gd_r;
    c_gn_r   <= b_gn_r;
    c_th_r   <= b_th_r;
  end

  // stage D: slow excitation, total inhibition
  always_ff @(posedge clk) begin
    d_gn_r  <= sat32(64'(c_gn_r) + rshr(64'(c_prod_r), 16));
    d_gi_r  <= sat32(64'(c_gg_r) + 64'(c_gd_r));
    d_mem_r <= c_mem_r;
    d_ga_r  <= c_ga_r;
    d_gg_r  <= c_gg_r;
    d_gd_r  <= c_gd_r;
    d_th_r  <= c_th_r;
  end

  // stage E: fast and slow shares of excitation
  always_comb begin
    e_slow_u = 17'd65536 - 17'(cfg.ampa_fraction);
    e_slow_f = $signed({1'b0, e_slow_u});
  end

  always_ff @(posedge clk) begin
    e_p1_r  <= d_ga_r * $signed({1'b0, cfg.ampa_fraction});
    e_p2_r  <= d_gn_r * e_slow_f;
    e_mem_r <= d_mem_r;
    e_ga_r  <= d_ga_r;
    e_gg_r  <= d_gg_r;
    e_gd_r  <= d_gd_r;
    e_gn_r  <= d_gn_r;
    e_th_r  <= d_th_r;
    e_gi_r  <= d_gi_r;
  end

  // stage F: excitatory conductance
  always_ff @(posedge clk) begin
    f_gexc_r <= sat32(rshr(64'(e_p1_r) + 64'(e_p2_r), 16));
    f_mem_r  <= e_mem_r;
    f_ga_r   <= e_ga_r;
    f_gg_r   <= e_gg_r;
    f_gd_r   <= e_gd_r;
    f_gn_r   <= e_gn_r;
    f_th_r   <= e_th_r;
    f_gi_r   <= e_gi_r;
  end

  // stage G: current products; membrane fits in 22 bits after the clamp
  always_comb begin
    g_nexc    = -(33'(f_gexc_r));
    g_mem22   = f_mem_r[21:0];
    g_above32 = f_mem_r - E_REV;
    g_above   = g_above32[21:0];
  end

  always_ff @(posedge clk) begin
    g_exc_r <= g_nexc * g_mem22;
    g_inh_r <= $signed({1'b0, g_above}) * f_gi_r;
    g_mem_r <= f_mem_r;
    g_ga_r  <= f_ga_r;
    g_gg_r  <= f_gg_r;
    g_gd_r  <= f_gd_r;
    g_gn_r  <= f_gn_r;
    g_th_r  <= f_th_r;
  end

  // stage H: net drive
  assign h_sum = rshr(64'(g_exc_r), 24) - rshr(64'(g_inh_r), 24)
               - (64'(g_mem_r) - 64'(E_REST));

  always_ff @(posedge clk) begin
    h_sum_r <= h_sum[39:0];
    h_mem_r <= g_mem_r;
    h_ga_r  <= g_ga_r;
    h_gg_r  <= g_gg_r;
    h_gd_r  <= g_gd_r;
    h_gn_r  <= g_gn_r;
    h_th_r  <= g_th_r;
  end

  // stage I: scale by membrane rate
  always_ff @(posedge clk) begin
    i_prod_r <= h_sum_r * $signed({1'b0, cfg.mem_rate});
    i_mem_r  <= h_mem_r;
    i_ga_r   <= h_ga_r;
    i_gg_r   <= h_gg_r;
    i_gd_r   <= h_gd_r;
    i_gn_r   <= h_gn_r;
    i_th_r   <= h_th_r;
  end

  // stage J: membrane update, clip, spike decision
  always_comb begin
    j_m = 64'(i_mem_r) + rshr(64'(i_prod_r), 16);
    if (j_m < 64'(E_REV)) j_m = 64'(E_REV);
    if (j_m > 64'sd0)     j_m = '0;
    j_fire = (j_m > 64'(V_THRESH_BASE) + 64'(i_th_r));
    j_st.fast  = i_ga_r;
    j_st.slow  = i_gn_r;
    j_st.inhib = i_gg_r;
    if (j_fire) begin
      j_st.mem   = E_REST;
      j_st.th    = DTHR;
      j_st.adapt = sat32(64'(i_gd_r) + 64'($signed({1'b0, cfg.adapt_increment})));
    end else begin
      j_st.mem   = j_m[31:0];
      j_st.th    = i_th_r;
      j_st.adapt = i_gd_r;
    end
  end

  // result of the last stage; out-of-range items report zero
  always_comb begin
    res.spike_index  = idx_r[PIPE_LAST];
    res.fired        = rng_r[PIPE_LAST] & j_fire;
    res.membrane_out = rng_r[PIPE_LAST] ? j_st.mem : '0;
  end

  assign opush     = vld_r[PIPE_LAST];
  assign out_valid = (ocnt_r != '0);
  assign opop      = out_valid & ~out_stall;
  assign out_item  = oq_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owr_r <= owr_r + 1'b1;
      if (opop)  ord_r <= ord_r + 1'b1;
      ocnt_r <= ocnt_r + (OQ_PTR_W+1)'(opush) - (OQ_PTR_W+1)'(opop);
    end
  end

  // hold finished items
  always_ff @(posedge clk) begin
    if (opush) oq_r[owr_r] <= res;
  end
endmodule
`default_nettype wire

@@ hdl/adaptive_conductance_lif_neuron.sv @@
// Top level: configuration registers, front part and back part of the neuron array
`default_nettype none
// Advances one neuron of a 1024-neuron adaptive conductance LIF array per item and returns
// one result per item, in order. After reset the block sweeps the state memory, one neuron
// a cycle; meanwhile up to four items are taken into the input queue but none is started
// (configuration writes are taken).
// Sustained rate is one item per cycle unless a neuron hazard or a full result queue holds
// items back; an item for a neuron still inside the update pipeline, between the state read
// and the write-back, waits until its predecessor has been written back. A four-entry input
// queue and a sixteen-entry result queue let each side stall on its own.
module adaptive_conductance_lif_neuron (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire acl_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output acl_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import acl_pkg::*;

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  work_t q_head;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ampa_decay      <= 16'd64238;
      cfg_r.gaba_decay      <= 16'd64884;
      cfg_r.adapt_decay     <= 16'd65470;
      cfg_r.thresh_decay    <= 16'd64238;
      cfg_r.nmda_rate       <= 16'd66;
      cfg_r.mem_rate        <= 16'd328;
      cfg_r.ampa_fraction   <= 16'd32768;
      cfg_r.adapt_increment <= 31'd1677722;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_AMPA_DECAY:   cfg_r.ampa_decay      <= cfg_data[15:0];
        REG_GABA_DECAY:   cfg_r.gaba_decay      <= cfg_data[15:0];
        REG_ADAPT_DECAY:  cfg_r.adapt_decay     <= cfg_data[15:0];
        REG_THRESH_DECAY: cfg_r.thresh_decay    <= cfg_data[15:0];
        REG_NMDA_RATE:    cfg_r.nmda_rate       <= cfg_data[15:0];
        REG_MEM_RATE:     cfg_r.mem_rate        <= cfg_data[15:0];
        REG_AMPA_FRAC:    cfg_r.ampa_fraction   <= cfg_data[15:0];
        REG_ADAPT_INC:    cfg_r.adapt_increment <= cfg_data;
        default:          cfg_r.adapt_increment <= cfg_r.adapt_increment;
      endcase
    end
  end

  acl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  acl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire
